// ===== sv/assert_macros.svh =====
// Assertion macros shared by the depth sentence encoder modules.
// Each macro expects i_clk in the scope where it is used; LSDN_ASSERT also expects i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSDN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LSDN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LSDN_ASSERT(lbl, prop, msg)
`define LSDN_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/lsdn_pkg.sv =====
// Types, character constants and segment pattern decoders for the depth encoder.
// No dependencies.
`default_nettype none
package lsdn_pkg;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    typedef struct packed {
        t_digit units;
        t_digit tens;
        logic   point;
        t_digit tenths;
    } t_frame;

    localparam logic [7:0] HEADER [5] = '{8'hCE, 8'h80, 8'hE0, 8'hF8, 8'h70};

    localparam logic [7:0] MASK_TENS   = 8'hFE;
    localparam logic [7:0] MASK_TENTHS = 8'hBF;
    localparam logic [7:0] MASK_UN_HI  = 8'h2F;
    localparam logic [7:0] MASK_UN_LO  = 8'hC0;

    localparam logic [6:0] LEAD_TEXT [7] = '{7'h24, 7'h53, 7'h44, 7'h44, 7'h50, 7'h54, 7'h2C};
    localparam logic [6:0] TAIL_TEXT [5] = '{7'h2C, 7'h30, 7'h2E, 7'h30, 7'h2A};
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A     = 7'h41;
    localparam logic [6:0] CH_POINT = 7'h2E;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_LF    = 7'h0A;

    // The fixed characters between the dollar sign and the asterisk, folded once.
    localparam logic [6:0] SUM_BASE = LEAD_TEXT[1] ^ LEAD_TEXT[2] ^ LEAD_TEXT[3] ^
                                      LEAD_TEXT[4] ^ LEAD_TEXT[5] ^ LEAD_TEXT[6] ^
                                      TAIL_TEXT[0] ^ TAIL_TEXT[1] ^ TAIL_TEXT[2] ^
                                      TAIL_TEXT[3];

    function automatic t_digit match_tens(input logic [7:0] v);
        t_digit d;
        d.ok = 1'b1;
        case (v)
            8'hEE: d.val = 4'd0;
            8'h44: d.val = 4'd1;
            8'hB6: d.val = 4'd2;
            8'hD6: d.val = 4'd3;
            8'h5C: d.val = 4'd4;
            8'hDA: d.val = 4'd5;
            8'hFA: d.val = 4'd6;
            8'h46: d.val = 4'd7;
            8'hFE: d.val = 4'd8;
            8'hDE: d.val = 4'd9;
            default: begin
                d.ok  = 1'b0;
                d.val = 4'd0;
            end
        endcase
        return d;
    endfunction

    function automatic t_digit match_tenths(input logic [7:0] v);
        t_digit d;
        d.ok = 1'b1;
        case (v)
            8'hBB: d.val = 4'd0;
            8'h11: d.val = 4'd1;
            8'h9E: d.val = 4'd2;
            8'h97: d.val = 4'd3;
            8'h35: d.val = 4'd4;
            8'hA7: d.val = 4'd5;
            8'hAF: d.val = 4'd6;
            8'h91: d.val = 4'd7;
            8'hBF: d.val = 4'd8;
            8'hB7: d.val = 4'd9;
            default: begin
                d.ok  = 1'b0;
                d.val = 4'd0;
            end
        endcase
        return d;
    endfunction

    function automatic t_digit match_units(input logic [7:0] hi, input logic [7:0] lo);
        t_digit d;
        logic [7:0] want_lo;
        d.ok    = 1'b1;
        want_lo = 8'hC0;
        case (hi)
            8'h2E: d.val = 4'd0;
            8'h04: begin d.val = 4'd1; want_lo = 8'h40; end
            8'h27: begin d.val = 4'd2; want_lo = 8'h80; end
            8'h25: d.val = 4'd3;
            8'h0D: begin d.val = 4'd4; want_lo = 8'h40; end
            8'h29: d.val = 4'd5;
            8'h2B: d.val = 4'd6;
            8'h24: begin d.val = 4'd7; want_lo = 8'h40; end
            8'h2F: d.val = 4'd8;
            8'h2D: d.val = 4'd9;
            default: begin
                d.ok  = 1'b0;
                d.val = 4'd0;
            end
        endcase
        if (lo != want_lo) begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    function automatic logic [6:0] digit_char(input logic [3:0] v);
        return CH_ZERO + {3'b000, v};
    endfunction

    function automatic logic [6:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? CH_ZERO + {3'b000, v} : CH_A + {3'b000, v - 4'd10};
    endfunction

endpackage
`default_nettype wire

// ===== sv/lsdn_framer.sv =====
// Header hunt, segment byte capture and digit decode into a pending frame register.
// Depends on lsdn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lsdn_framer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_rx_valid,
    output logic               o_rx_ready,
    input  wire logic          i_frame_take,
    output logic               o_frame_valid,
    output lsdn_pkg::t_frame   o_frame
);
    import lsdn_pkg::*;

    localparam logic [3:0] POS_SEG0 = 4'd5;
    localparam logic [3:0] POS_LAST = 4'd10;

    logic [3:0] r_pos, n_pos;
    logic [7:0] r_seg0, r_seg1, r_seg3, r_seg4;
    logic       r_frame_valid;
    t_frame     r_frame;
    t_frame     n_frame;
    logic       w_accept, w_sentence;
    logic [7:0] w_s0, w_s1, w_s3, w_s4, w_s5;

    assign o_rx_ready = !(r_pos == POS_LAST && r_frame_valid && !i_frame_take);
    assign w_accept   = i_rx_valid && o_rx_ready;

    // The sixth segment byte is decoded straight from the input.
    assign w_s0 = r_seg0;
    assign w_s1 = r_seg1;
    assign w_s3 = r_seg3;
    assign w_s4 = r_seg4;
    assign w_s5 = i_rx_byte;

    always_comb begin
        n_frame.tens   = match_tens(w_s0 & MASK_TENS);
        n_frame.tenths = match_tenths(w_s1 & MASK_TENTHS);
        n_frame.units  = match_units(w_s4 & MASK_UN_HI, w_s5 & MASK_UN_LO);
        n_frame.point  = w_s3[7];
        w_sentence     = w_s0[0] &&
                         (n_frame.tens.ok || n_frame.tenths.ok || n_frame.units.ok);
    end

    always_comb begin
        if (r_pos < POS_SEG0) begin
            n_pos = (i_rx_byte == HEADER[r_pos[2:0]]) ? r_pos + 4'd1 : 4'd0;
        end else if (r_pos < POS_LAST) begin
            n_pos = r_pos + 4'd1;
        end else begin
            n_pos = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= 4'd0;
            r_frame_valid <= 1'b0;
        end else begin
            if (w_accept && r_pos == POS_LAST && w_sentence) begin
                r_frame_valid <= 1'b1;
            end else if (i_frame_take) begin
                r_frame_valid <= 1'b0;
            end
            if (w_accept) begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            case (r_pos)
                4'd5:    r_seg0 <= i_rx_byte;
                4'd6:    r_seg1 <= i_rx_byte;
                4'd8:    r_seg3 <= i_rx_byte;
                4'd9:    r_seg4 <= i_rx_byte;
                default: ;
            endcase
            if (r_pos == POS_LAST) begin
                r_frame <= n_frame;
            end
        end
    end

    assign o_frame_valid = r_frame_valid;
    assign o_frame       = r_frame;

    `LSDN_ASSERT(a_pos_range, r_pos <= POS_LAST, "hunt position out of range")
    `LSDN_ASSERT(a_frame_kept, r_frame_valid && !i_frame_take |=> r_frame_valid,
        "pending frame lost before it was taken")

endmodule
`default_nettype wire

// ===== sv/lsdn_emitter.sv =====
// Character sequencer that turns a decoded frame into the depth sentence.
// Depends on lsdn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lsdn_emitter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_frame_valid,
    input  wire lsdn_pkg::t_frame i_frame,
    output logic               o_frame_take,
    output logic [6:0]         o_out_char,
    output logic               o_last_char,
    output logic               o_out_valid,
    input  wire logic          i_out_ready
);
    import lsdn_pkg::*;

    localparam logic [4:0] SLOT_UNITS  = 5'd7;
    localparam logic [4:0] SLOT_TENS   = 5'd8;
    localparam logic [4:0] SLOT_POINT  = 5'd9;
    localparam logic [4:0] SLOT_TENTHS = 5'd10;
    localparam logic [4:0] SLOT_TAIL   = 5'd11;
    localparam logic [4:0] SLOT_HEX_HI = 5'd16;
    localparam logic [4:0] SLOT_HEX_LO = 5'd17;
    localparam logic [4:0] SLOT_CR     = 5'd18;
    localparam logic [4:0] SLOT_LF     = 5'd19;

    logic       r_busy;
    logic [4:0] r_slot, n_slot;
    t_frame     r_frame;
    logic [6:0] r_char, n_char;
    logic       r_last, r_valid;
    logic       w_adv;
    logic [3:0] w_present;
    logic [6:0] w_sum;
    logic [4:0] w_tail_off;

    assign w_adv        = !r_valid || i_out_ready;
    assign o_frame_take = !r_busy && i_frame_valid;

    assign w_present = {r_frame.units.ok, r_frame.tens.ok, r_frame.point, r_frame.tenths.ok};

    assign w_sum = SUM_BASE
                 ^ (r_frame.units.ok  ? digit_char(r_frame.units.val)  : 7'd0)
                 ^ (r_frame.tens.ok   ? digit_char(r_frame.tens.val)   : 7'd0)
                 ^ (r_frame.point     ? CH_POINT                       : 7'd0)
                 ^ (r_frame.tenths.ok ? digit_char(r_frame.tenths.val) : 7'd0);

    assign w_tail_off = r_slot - SLOT_TAIL;

    always_comb begin
        n_slot = r_slot + 5'd1;
        for (int i = 0; i < 4; i++) begin
            if (n_slot == SLOT_UNITS + 5'(i) && !w_present[3 - i]) begin
                n_slot = n_slot + 5'd1;
            end
        end
    end

    always_comb begin
        unique case (r_slot) inside
            [5'd0:5'd6]:  n_char = LEAD_TEXT[r_slot[2:0]];
            SLOT_UNITS:   n_char = digit_char(r_frame.units.val);
            SLOT_TENS:    n_char = digit_char(r_frame.tens.val);
            SLOT_POINT:   n_char = CH_POINT;
            SLOT_TENTHS:  n_char = digit_char(r_frame.tenths.val);
            [5'd11:5'd15]: n_char = TAIL_TEXT[w_tail_off[2:0]];
            SLOT_HEX_HI:  n_char = hex_char({1'b0, w_sum[6:4]});
            SLOT_HEX_LO:  n_char = hex_char(w_sum[3:0]);
            SLOT_CR:      n_char = CH_CR;
            SLOT_LF:      n_char = CH_LF;
            default:      n_char = CH_LF;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_slot  <= 5'd0;
        end else begin
            if (w_adv) begin
                r_valid <= r_busy;
                if (r_busy) begin
                    if (r_slot == SLOT_LF) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_slot <= n_slot;
                    end
                end
            end
            if (o_frame_take) begin
                r_busy <= 1'b1;
                r_slot <= 5'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_busy) begin
            r_char <= n_char;
            r_last <= (r_slot == SLOT_LF);
        end
        if (o_frame_take) begin
            r_frame <= i_frame;
        end
    end

    assign o_out_char  = r_char;
    assign o_last_char = r_last;
    assign o_out_valid = r_valid;

    `LSDN_ASSERT(a_last_is_lf, r_valid && r_last |-> r_char == CH_LF,
        "last character is not a line feed")
    `LSDN_ASSERT(a_slot_range, r_busy |-> r_slot <= SLOT_LF, "slot beyond sentence end")
    `LSDN_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !r_busy && !r_valid,
        "sequencer active after reset")

endmodule
`default_nettype wire

// ===== sv/lcd_segment_depth_to_nmea_top.sv =====
// Top level of the LCD segment depth to NMEA depth sentence encoder.
// Depends on lsdn_pkg, lsdn_framer and lsdn_emitter.
//
//   channel   valid        ready        payload
//   input     i_rx_valid   o_rx_ready   i_rx_byte
//   output    o_out_valid  i_out_ready  o_out_char, o_last_char
//
// One display byte is taken per cycle; a completed frame is decoded in the cycle
// its last byte is accepted and sits in one pending frame register.
// The sequencer sends one character per cycle while i_out_ready holds, 17 to 20 per
// sentence. The input stalls only on a frame's last byte while the previous frame
// still waits. Synchronous reset returns to header hunting.
`default_nettype none
module lcd_segment_depth_to_nmea_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_rx_valid,
    output logic            o_rx_ready,
    output logic [6:0]      o_out_char,
    output logic            o_last_char,
    output logic            o_out_valid,
    input  wire logic       i_out_ready
);
    import lsdn_pkg::*;

    logic   w_frame_valid, w_frame_take;
    t_frame w_frame;

    lsdn_framer u_framer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_byte     (i_rx_byte),
        .i_rx_valid    (i_rx_valid),
        .o_rx_ready    (o_rx_ready),
        .i_frame_take  (w_frame_take),
        .o_frame_valid (w_frame_valid),
        .o_frame       (w_frame)
    );

    lsdn_emitter u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (w_frame_valid),
        .i_frame       (w_frame),
        .o_frame_take  (w_frame_take),
        .o_out_char    (o_out_char),
        .o_last_char   (o_last_char),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready)
    );

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for lcd_segment_depth_to_nmea_top: feeds display bus words and
// checks every depth sentence character against a built-in predictor.
// Depends only on the RTL of the encoder.
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_sentence_char;

    localparam int HDR_LEN   = 5;
    localparam int FRAME_END = 10;
    localparam int NO_DIGIT  = -1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 60;

    localparam logic [7:0] HDR_SEQ    [5]  = '{8'hCE, 8'h80, 8'hE0, 8'hF8, 8'h70};
    localparam logic [7:0] TENS_SEG   [10] = '{8'hEE, 8'h44, 8'hB6, 8'hD6, 8'h5C,
                                               8'hDA, 8'hFA, 8'h46, 8'hFE, 8'hDE};
    localparam logic [7:0] TENTHS_SEG [10] = '{8'hBB, 8'h11, 8'h9E, 8'h97, 8'h35,
                                               8'hA7, 8'hAF, 8'h91, 8'hBF, 8'hB7};
    localparam logic [7:0] UNITS_HI   [10] = '{8'h2E, 8'h04, 8'h27, 8'h25, 8'h0D,
                                               8'h29, 8'h2B, 8'h24, 8'h2F, 8'h2D};
    localparam logic [7:0] UNITS_LO   [10] = '{8'hC0, 8'h40, 8'h80, 8'hC0, 8'h40,
                                               8'hC0, 8'hC0, 8'h40, 8'hC0, 8'hC0};

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic [7:0] i_rx_byte;
    logic       i_rx_valid;
    logic       o_rx_ready;
    logic [6:0] o_out_char;
    logic       o_last_char;
    logic       o_out_valid;
    logic       i_out_ready;

    logic [3:0] hunt_pos;
    logic [7:0] seg_store [6];
    t_sentence_char expected_chars [$];

    bit src_gaps;
    bit sink_gaps;
    int bytes_sent;
    int err_count;
    int cycle_count;

    lcd_segment_depth_to_nmea_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (i_rx_byte),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready <= sink_gaps ? ($urandom_range(0, 99) >= 12) : 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[lcd_segment_depth_to_nmea_top] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_sentence_char want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %h", o_out_char));
            end else begin
                want = expected_chars.pop_front();
                if (o_out_char !== want.ch) begin
                    report_mismatch($sformatf("char %h, want %h", o_out_char, want.ch));
                end
                if (o_last_char !== want.last) begin
                    report_mismatch($sformatf("last flag %b, want %b on char %h",
                                              o_last_char, want.last, want.ch));
                end
            end
        end
    end

    function automatic int find_digit(input logic [7:0] pat [10], input logic [7:0] v);
        for (int d = 0; d < 10; d++) begin
            if (pat[d] == v) begin
                return d;
            end
        end
        return NO_DIGIT;
    endfunction

    function automatic int find_units(input logic [7:0] hi, input logic [7:0] lo);
        for (int d = 0; d < 10; d++) begin
            if (UNITS_HI[d] == hi && UNITS_LO[d] == lo) begin
                return d;
            end
        end
        return NO_DIGIT;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + {4'd0, v} : 8'h41 + {4'd0, v - 4'd10};
    endfunction

    task automatic queue_depth_sentence();
        int tens;
        int tenths;
        int units;
        string line;
        logic [7:0] sum;
        logic [7:0] c;
        t_sentence_char item;
        tens   = find_digit(TENS_SEG, seg_store[0] & 8'hFE);
        tenths = find_digit(TENTHS_SEG, seg_store[1] & 8'hBF);
        units  = find_units(seg_store[4] & 8'h2F, seg_store[5] & 8'hC0);
        sum    = 8'h00;
        if (!seg_store[0][0] || (tens == NO_DIGIT && tenths == NO_DIGIT &&
                                 units == NO_DIGIT)) begin
            return;
        end
        line = "$SDDPT,";
        if (units != NO_DIGIT) line = {line, $sformatf("%0d", units)};
        if (tens != NO_DIGIT) line = {line, $sformatf("%0d", tens)};
        if (seg_store[3][7]) line = {line, "."};
        if (tenths != NO_DIGIT) line = {line, $sformatf("%0d", tenths)};
        line = {line, ",0.0*"};
        for (int k = 1; k < line.len() - 1; k++) begin
            sum ^= line[k];
        end
        line = {line, $sformatf("%c%c", hex_ascii(sum[7:4]), hex_ascii(sum[3:0])), "\r\n"};
        for (int k = 0; k < line.len(); k++) begin
            c         = line[k];
            item.ch   = c[6:0];
            item.last = (k == line.len() - 1);
            expected_chars.push_back(item);
        end
    endtask

    task automatic predict_rx(input logic [7:0] b);
        if (hunt_pos > FRAME_END) begin
            hunt_pos = 4'd0;
        end
        if (hunt_pos < HDR_LEN) begin
            hunt_pos = (b == HDR_SEQ[hunt_pos]) ? hunt_pos + 4'd1 : 4'd0;
        end else begin
            seg_store[hunt_pos - HDR_LEN] = b;
            if (hunt_pos < FRAME_END) begin
                hunt_pos = hunt_pos + 4'd1;
            end else begin
                hunt_pos = 4'd0;
                queue_depth_sentence();
            end
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_byte(input logic [7:0] b);
        if (src_gaps) begin
            while ($urandom_range(0, 99) < 12) begin
                i_rx_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        predict_rx(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [47:0] segs);
        for (int k = 0; k < HDR_LEN; k++) send_byte(HDR_SEQ[k]);
        for (int k = 0; k < 6; k++) send_byte(segs[8 * k +: 8]);
    endtask

    task automatic wait_sentences_out();
        i_rx_valid <= 1'b0;
        do @(negedge i_clk); while (expected_chars.size() != 0);
    endtask

    function automatic logic [47:0] random_frame();
        logic [7:0] seg [6];
        int du;
        for (int k = 0; k < 6; k++) seg[k] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) begin
            seg[0] = TENS_SEG[$urandom_range(0, 9)] | (seg[0] & 8'h01);
        end
        seg[0][0] = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 3) != 0) begin
            seg[1] = TENTHS_SEG[$urandom_range(0, 9)] | (seg[1] & 8'h40);
        end
        if ($urandom_range(0, 3) != 0) begin
            du = $urandom_range(0, 9);
            seg[4] = UNITS_HI[du] | (seg[4] & 8'hD0);
            if ($urandom_range(0, 4) == 0) du = $urandom_range(0, 9);
            seg[5] = UNITS_LO[du] | (seg[5] & 8'h3F);
        end
        return {seg[5], seg[4], seg[3], seg[2], seg[1], seg[0]};
    endfunction

    task automatic test_header_hunt();
        send_byte(8'h00);
        send_byte(8'hFF);
        // A header start byte that breaks a partial header is dropped.
        send_byte(HDR_SEQ[0]);
        send_byte(HDR_SEQ[1]);
        send_byte(HDR_SEQ[2]);
        send_byte(HDR_SEQ[0]);
        send_frame({UNITS_LO[8], UNITS_HI[8], 8'h80, 8'hFF, TENTHS_SEG[7],
                    TENS_SEG[9] | 8'h01});
    endtask

    task automatic test_point_without_digits();
        // Follows the previous frame directly, so its header is hunted at once.
        send_frame({8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h01});
        wait_sentences_out();
    endtask

    task automatic test_random_traffic(input int word_count);
        int stop_at;
        int pick;
        int depth;
        stop_at = bytes_sent + word_count;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(random_frame());
            end else if (pick < 85) begin
                depth = $urandom_range(1, HDR_LEN - 1);
                for (int k = 0; k < depth; k++) send_byte(HDR_SEQ[k]);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
        wait_sentences_out();
    endtask

    task automatic test_no_gap_stretch(input int frame_count);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        for (int n = 0; n < frame_count; n++) send_frame(random_frame());
        wait_sentences_out();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_rx_byte   = 8'h00;
        i_rx_valid  = 1'b0;
        src_gaps    = 1'b1;
        sink_gaps   = 1'b1;
        hunt_pos    = 4'd0;
        bytes_sent  = 0;
        for (int k = 0; k < 6; k++) seg_store[k] = 8'h00;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_header_hunt();
        test_point_without_digits();
        test_random_traffic(180);
        test_no_gap_stretch(6);

        i_rx_valid <= 1'b0;
        while (expected_chars.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[lcd_segment_depth_to_nmea_top] OK");
        end else begin
            $display("[lcd_segment_depth_to_nmea_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lsdn_pkg.sv
sv/lsdn_framer.sv
sv/lsdn_emitter.sv
sv/lcd_segment_depth_to_nmea_top.sv
verif/tb.sv
